// ----- design/tksd_pkg.sv -----
`default_nettype none
package tksd_pkg;

	localparam int BufDepth   = 8;
	localparam int NumEntries = 62;
	localparam int MaxLen     = 7;
	localparam int CntW       = $clog2(BufDepth + 1);
	localparam int IdxW       = $clog2(BufDepth);

	localparam logic [0:0] CmdByte    = 1'b0;
	localparam logic [0:0] CmdTimeout = 1'b1;

	localparam logic [0:0] RegRawMode    = 1'b0;
	localparam logic [0:0] RegRawControl = 1'b1;

	typedef struct packed {
		logic [7:0]      s0, s1, s2, s3, s4, s5, s6;
		logic [2:0]      len;
		logic [4:0]      key;
		logic            ctl;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_ACT,
		ST_POST,
		ST_FLUSH,
		ST_EMIT,
		ST_DOOR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input word
		logic drain;     // one drain step
		logic force_one; // one forced decision
		logic push;      // append input byte
		logic emit_in;   // emit from input word
		logic emit_dw;   // doorway timeout char
		logic dw_set;    // enter doorway mode
		logic dw_clr;    // leave doorway mode
		logic mark_last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic drain_stop; // drain cannot decide more
		logic doorway;
		logic cmd;
		logic byte_zero;
		logic remote;
		logic out_busy;   // result queue not empty
	} dp_sts_t;

	function automatic entry_t mk(input logic [7:0] a, b, c, d, e, f, g,
		input int l, input int k, input bit ct);
		entry_t r;
		r.s0 = a; r.s1 = b; r.s2 = c; r.s3 = d; r.s4 = e; r.s5 = f; r.s6 = g;
		r.len = 3'(l); r.key = 5'(k); r.ctl = ct;
		return r;
	endfunction

	function automatic entry_t tbl(input logic [5:0] i);
		entry_t r;
		r = '0;
		case (i)
			6'd0:  r = mk(8'h1b, "A", 0, 0, 0, 0, 0, 2, 0, 0);
			6'd1:  r = mk(8'h1b, "B", 0, 0, 0, 0, 0, 2, 1, 0);
			6'd2:  r = mk(8'h1b, "C", 0, 0, 0, 0, 0, 2, 3, 0);
			6'd3:  r = mk(8'h1b, "D", 0, 0, 0, 0, 0, 2, 2, 0);
			6'd4:  r = mk(8'h1b, "H", 0, 0, 0, 0, 0, 2, 6, 0);
			6'd5:  r = mk(8'h1b, "K", 0, 0, 0, 0, 0, 2, 7, 0);
			6'd6:  r = mk(8'h1b, "P", 0, 0, 0, 0, 0, 2, 10, 0);
			6'd7:  r = mk(8'h1b, "Q", 0, 0, 0, 0, 0, 2, 11, 0);
			6'd8:  r = mk(8'h1b, "?", "w", 0, 0, 0, 0, 3, 12, 0);
			6'd9:  r = mk(8'h1b, "?", "x", 0, 0, 0, 0, 3, 13, 0);
			6'd10: r = mk(8'h1b, "?", "t", 0, 0, 0, 0, 3, 14, 0);
			6'd11: r = mk(8'h1b, "?", "u", 0, 0, 0, 0, 3, 15, 0);
			6'd12: r = mk(8'h1b, "?", "q", 0, 0, 0, 0, 3, 16, 0);
			6'd13: r = mk(8'h1b, "?", "r", 0, 0, 0, 0, 3, 17, 0);
			6'd14: r = mk(8'h1b, "?", "p", 0, 0, 0, 0, 3, 18, 0);
			6'd15: r = mk(8'h1b, "[", "A", 0, 0, 0, 0, 3, 0, 0);
			6'd16: r = mk(8'h1b, "[", "B", 0, 0, 0, 0, 3, 1, 0);
			6'd17: r = mk(8'h1b, "[", "C", 0, 0, 0, 0, 3, 3, 0);
			6'd18: r = mk(8'h1b, "[", "D", 0, 0, 0, 0, 3, 2, 0);
			6'd19: r = mk(8'h1b, "[", "M", 0, 0, 0, 0, 3, 8, 0);
			6'd20: r = mk(8'h1b, "[", "H", 8'h1b, "[", "2", "J", 7, 9, 0);
			6'd21: r = mk(8'h1b, "[", "H", 0, 0, 0, 0, 3, 6, 0);
			6'd22: r = mk(8'h1b, "[", "K", 0, 0, 0, 0, 3, 7, 0);
			6'd23: r = mk(8'h1b, "O", "P", 0, 0, 0, 0, 3, 10, 0);
			6'd24: r = mk(8'h1b, "O", "Q", 0, 0, 0, 0, 3, 11, 0);
			6'd25: r = mk(8'h1b, "O", "R", 0, 0, 0, 0, 3, 12, 0);
			6'd26: r = mk(8'h1b, "O", "S", 0, 0, 0, 0, 3, 13, 0);
			6'd27: r = mk(8'h1b, "[", "1", "~", 0, 0, 0, 4, 6, 0);
			6'd28: r = mk(8'h1b, "[", "2", "~", 0, 0, 0, 4, 4, 0);
			6'd29: r = mk(8'h1b, "[", "3", "~", 0, 0, 0, 4, 5, 0);
			6'd30: r = mk(8'h1b, "[", "4", "~", 0, 0, 0, 4, 7, 0);
			6'd31: r = mk(8'h1b, "[", "5", "~", 0, 0, 0, 4, 8, 0);
			6'd32: r = mk(8'h1b, "[", "6", "~", 0, 0, 0, 4, 9, 0);
			6'd33: r = mk(8'h1b, "[", "1", "7", "~", 0, 0, 5, 15, 0);
			6'd34: r = mk(8'h1b, "[", "1", "8", "~", 0, 0, 5, 16, 0);
			6'd35: r = mk(8'h1b, "[", "1", "9", "~", 0, 0, 5, 17, 0);
			6'd36: r = mk(8'h1b, "[", "2", "0", "~", 0, 0, 5, 18, 0);
			6'd37: r = mk(8'h1b, "[", "2", "1", "~", 0, 0, 5, 19, 0);
			6'd38: r = mk(8'h1b, "[", "2", "3", "~", 0, 0, 5, 20, 0);
			6'd39: r = mk(8'h1b, "[", "2", "4", "~", 0, 0, 5, 21, 0);
			6'd40: r = mk(8'h1b, "[", "L", 0, 0, 0, 0, 3, 6, 0);
			6'd41: r = mk(8'h1b, "O", "w", 0, 0, 0, 0, 3, 12, 0);
			6'd42: r = mk(8'h1b, "O", "x", 0, 0, 0, 0, 3, 13, 0);
			6'd43: r = mk(8'h1b, "O", "t", 0, 0, 0, 0, 3, 14, 0);
			6'd44: r = mk(8'h1b, "O", "u", 0, 0, 0, 0, 3, 15, 0);
			6'd45: r = mk(8'h1b, "O", "q", 0, 0, 0, 0, 3, 16, 0);
			6'd46: r = mk(8'h1b, "O", "r", 0, 0, 0, 0, 3, 17, 0);
			6'd47: r = mk(8'h1b, "O", "p", 0, 0, 0, 0, 3, 18, 0);
			6'd48: r = mk(8'h1b, "O", "A", 0, 0, 0, 0, 3, 0, 0);
			6'd49: r = mk(8'h1b, "O", "B", 0, 0, 0, 0, 3, 1, 0);
			6'd50: r = mk(8'h1b, "O", "C", 0, 0, 0, 0, 3, 3, 0);
			6'd51: r = mk(8'h1b, "O", "D", 0, 0, 0, 0, 3, 2, 0);
			6'd52: r = mk(8'h1b, "O", "H", 0, 0, 0, 0, 3, 6, 0);
			6'd53: r = mk(8'h1b, "O", "K", 0, 0, 0, 0, 3, 7, 0);
			6'd54: r = mk(8'h16, 8'h09, 0, 0, 0, 0, 0, 2, 4, 1);
			6'd55: r = mk(8'h7f, 0, 0, 0, 0, 0, 0, 1, 5, 0);
			6'd56: r = mk(8'h05, 0, 0, 0, 0, 0, 0, 1, 0, 1);
			6'd57: r = mk(8'h18, 0, 0, 0, 0, 0, 0, 1, 1, 1);
			6'd58: r = mk(8'h13, 0, 0, 0, 0, 0, 0, 1, 2, 1);
			6'd59: r = mk(8'h04, 0, 0, 0, 0, 0, 0, 1, 3, 1);
			6'd60: r = mk(8'h07, 0, 0, 0, 0, 0, 0, 1, 5, 1);
			6'd61: r = mk(8'h16, 0, 0, 0, 0, 0, 0, 1, 4, 1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/tksd_ctrl.sv -----
`default_nettype none
module tksd_ctrl
	import tksd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_fire,
	input  dp_sts_t      sts,
	output dp_cmd_t      cmd,
	output logic         in_ready
);

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = sts.doorway ? ST_DOOR : ST_PRE;
			ST_PRE:  if (sts.empty || sts.drain_stop) state_d = ST_ACT;
			ST_ACT: begin
				if (sts.cmd == CmdTimeout) state_d = sts.empty ? ST_EMIT : ST_POST;
				else if (sts.byte_zero) state_d = sts.empty ? ST_EMIT : ST_FLUSH;
				else if (!sts.remote) state_d = ST_EMIT;
				else if (!sts.full) state_d = ST_POST;
			end
			ST_POST:  if (sts.empty || sts.drain_stop) state_d = ST_EMIT;
			ST_FLUSH: if (sts.empty) state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			ST_DOOR:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE) && !sts.out_busy;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_fire;
			end
			ST_PRE: cmd.drain = !sts.empty;
			ST_ACT: begin
				if (sts.doorway) begin
					cmd.dw_clr = 1'b1;
				end else if (sts.cmd == CmdTimeout) begin
					cmd.force_one = !sts.empty;
				end else if (sts.byte_zero) begin
					cmd.dw_set = sts.empty;
				end else if (!sts.remote) begin
					cmd.emit_in = 1'b1;
				end else if (sts.full) begin
					cmd.force_one = 1'b1;
				end else begin
					cmd.push = 1'b1;
				end
			end
			ST_POST: cmd.drain = !sts.empty;
			ST_FLUSH: begin
				cmd.force_one = !sts.empty;
				cmd.dw_set = sts.empty;
			end
			ST_EMIT: begin
				cmd.mark_last = 1'b1;
			end
			// word taken while doorway mode is active
			ST_DOOR: begin
				cmd.emit_in = (sts.cmd == CmdByte);
				cmd.emit_dw = (sts.cmd == CmdTimeout);
				cmd.dw_clr = 1'b1;
				cmd.mark_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ----- design/tksd_dp.sv -----
`default_nettype none
module tksd_dp
	import tksd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       raw_mode,
	input  wire logic       raw_control,
	input  wire logic       in_cmd,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_remote,
	input  dp_cmd_t         cmd,
	output dp_sts_t         sts,
	output logic [7:0]      out_code,
	output logic            out_ext,
	output logic            out_rem,
	output logic            out_last,
	output logic            out_valid,
	input  wire logic       out_take
);

	logic [7:0]      buf_q [BufDepth];
	logic [CntW-1:0] cnt_q;
	logic            dw_q;
	logic            lrem_q;
	logic            icmd_q, irem_q;
	logic [7:0]      ibyte_q;

	// result queue
	localparam int QD = 8;
	logic [9:0]      q_q [QD];
	logic [2:0]      qwr_q, qrd_q;
	logic [3:0]      qn_q;
	logic            qlast_q [QD];

	// table match over all entries
	logic            start_any;
	logic            longer_any;
	logic [2:0]      best_len;
	logic [4:0]      best_key;
	logic [7:0]      pb [MaxLen];

	always_comb begin
		entry_t e;
		logic   en, ag;
		logic [2:0] m;
		start_any = 1'b0;
		longer_any = 1'b0;
		best_len = '0;
		best_key = '0;
		for (int k = 0; k < MaxLen; k++) pb[k] = buf_q[k];
		for (int i = 0; i < NumEntries; i++) begin
			e = tbl(6'(i));
			en = !(raw_control && e.ctl) && !raw_mode;
			m = ({1'b0, e.len} < 4'(cnt_q)) ? e.len : 3'(cnt_q);
			ag = 1'b1;
			if (m > 3'd0 && e.s0 != pb[0]) ag = 1'b0;
			if (m > 3'd1 && e.s1 != pb[1]) ag = 1'b0;
			if (m > 3'd2 && e.s2 != pb[2]) ag = 1'b0;
			if (m > 3'd3 && e.s3 != pb[3]) ag = 1'b0;
			if (m > 3'd4 && e.s4 != pb[4]) ag = 1'b0;
			if (m > 3'd5 && e.s5 != pb[5]) ag = 1'b0;
			if (m > 3'd6 && e.s6 != pb[6]) ag = 1'b0;
			if (en && ag) begin
				start_any = 1'b1;
				if ({1'b0, e.len} > 4'(cnt_q)) longer_any = 1'b1;
				else if (e.len > best_len) begin
					best_len = e.len;
					best_key = e.key;
				end
			end
		end
	end

	// drain step: char if no start, key if decided, otherwise stop
	logic d_char, d_key, f_key;
	assign d_char = !start_any;
	assign d_key  = start_any && !longer_any && best_len != '0;
	assign f_key  = best_len != '0;

	logic            do_emit, e_ext, e_rem;
	logic [7:0]      e_code;
	logic [CntW-1:0] sh;
	always_comb begin
		do_emit = 1'b0; e_ext = 1'b0; e_rem = 1'b1; e_code = buf_q[0]; sh = '0;
		if (cmd.drain && (d_char || d_key)) begin
			do_emit = 1'b1;
			e_ext = d_key;
			e_code = d_key ? {3'b0, best_key} : buf_q[0];
			sh = d_key ? CntW'(best_len) : CntW'(1);
		end else if (cmd.force_one) begin
			do_emit = 1'b1;
			e_ext = f_key;
			e_code = f_key ? {3'b0, best_key} : buf_q[0];
			sh = f_key ? CntW'(best_len) : CntW'(1);
		end else if (cmd.emit_in) begin
			do_emit = 1'b1;
			e_ext = dw_q;
			e_rem = irem_q;
			e_code = ibyte_q;
		end else if (cmd.emit_dw) begin
			do_emit = 1'b1;
			e_code = 8'h00;
			e_rem = lrem_q;
		end
	end

	// flush with buffered bytes: doorway source forced to one
	logic flushed_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) flushed_q <= 1'b0;
		else if (cmd.load) flushed_q <= 1'b0;
		else if (cmd.force_one && icmd_q == CmdByte && ibyte_q == 8'h00) flushed_q <= 1'b1;
	end

	// buffer and mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dw_q <= 1'b0;
			lrem_q <= 1'b1;
			for (int k = 0; k < BufDepth; k++) buf_q[k] <= '0;
		end else begin
			if (sh != '0) begin
				for (int k = 0; k < BufDepth; k++)
					buf_q[k] <= (32'(k) + 32'(sh) < BufDepth) ? buf_q[k + int'(sh)] : 8'h00;
				cnt_q <= (sh >= cnt_q) ? '0 : cnt_q - sh;
			end else if (cmd.push) begin
				buf_q[cnt_q[IdxW-1:0]] <= ibyte_q;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.dw_set) begin
				dw_q <= 1'b1;
				lrem_q <= flushed_q ? 1'b1 : irem_q;
			end
			if (cmd.dw_clr && cmd.mark_last) dw_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			icmd_q <= in_cmd;
			ibyte_q <= in_byte;
			irem_q <= in_remote;
		end
	end

	// result queue, last flag set on the newest entry at the end of an item
	logic [3:0] qn_d;
	always_comb begin
		qn_d = qn_q;
		if (do_emit) qn_d = qn_d + 4'd1;
		if (out_take) qn_d = qn_d - 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qwr_q <= '0; qrd_q <= '0; qn_q <= '0;
			for (int k = 0; k < QD; k++) qlast_q[k] <= 1'b0;
		end else begin
			if (do_emit) begin
				qwr_q <= qwr_q + 1'b1;
				qlast_q[qwr_q] <= cmd.mark_last;
			end else if (cmd.mark_last && qn_q != '0) begin
				qlast_q[qwr_q - 1'b1] <= 1'b1;
			end
			if (out_take) qrd_q <= qrd_q + 1'b1;
			qn_q <= qn_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) q_q[qwr_q] <= {e_code, e_ext, e_rem};
	end

	// results leave only once the item is complete
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else if (cmd.load) done_q <= 1'b0;
		else if (cmd.mark_last) done_q <= 1'b1;
	end

	assign out_valid = done_q && qn_q != '0;
	assign out_code  = q_q[qrd_q][9:2];
	assign out_ext   = q_q[qrd_q][1];
	assign out_rem   = q_q[qrd_q][0];
	assign out_last  = qlast_q[qrd_q];

	assign sts.empty      = cnt_q == '0;
	assign sts.full       = cnt_q >= CntW'(BufDepth);
	assign sts.drain_stop = !(d_char || d_key);
	assign sts.doorway    = dw_q;
	assign sts.cmd        = icmd_q;
	assign sts.byte_zero  = ibyte_q == 8'h00;
	assign sts.remote     = irem_q;
	assign sts.out_busy   = qn_q != '0;

endmodule
`default_nettype wire

// ----- design/terminal_key_sequence_decoder.sv -----
`default_nettype none
// Terminal key decoder: takes key bytes and timeout ticks, one word at a time,
// and returns plain characters or extended key codes. A word taken while
// doorway mode is active goes from accept to a doorway step. Any other word goes
// through accept, drain check, action and finish, with an extra step when the
// buffer is touched after the action, and results are resolved from the buffer
// against the 62-entry sequence table, which is matched in parallel each step.
// Results of one word leave after the word is fully handled; the next word is
// taken once all results are delivered.
module terminal_key_sequence_decoder
	import tksd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [0:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // key_byte[7:0], from_remote[8], zero pad
	input  wire logic        s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // key_code[7:0], is_extended[8], remote_source[9]
	output logic             m_tlast
);

	logic    raw_mode_q, raw_control_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_fire;
	logic [7:0] code;
	logic    ext, rem;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
			raw_control_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == RegRawMode) raw_mode_q <= cfg_data[0];
			if (cfg_index == RegRawControl) raw_control_q <= cfg_data[0];
		end
	end

	assign in_fire = s_tvalid && s_tready;

	tksd_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .sts, .cmd, .in_ready(s_tready)
	);

	tksd_dp u_dp (
		.clk, .arst_n,
		.raw_mode(raw_mode_q), .raw_control(raw_control_q),
		.in_cmd(s_tuser), .in_byte(s_tdata[7:0]), .in_remote(s_tdata[8]),
		.cmd, .sts,
		.out_code(code), .out_ext(ext), .out_rem(rem), .out_last(m_tlast),
		.out_valid(m_tvalid), .out_take(m_tvalid && m_tready)
	);

	assign m_tdata = {6'b0, rem, ext, code};

	// no input taken while results are waiting
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with results pending");
	// no word follows the last one of an item
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid) else $error("result after last");
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready) else $error("ready held after accept");

endmodule
`default_nettype wire
